### design/quaternion_alu_macros.svh
// Assertion macros for the quaternion ALU checker.
// No dependencies.
`ifndef QUATERNION_ALU_MACROS_SVH
`define QUATERNION_ALU_MACROS_SVH
// implication checked each clock, reset disables
`define QA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define QA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/qalu_pkg.sv
// Package for the quaternion ALU: function codes, default widths and the front queue depth.
// No dependencies.
package qalu_pkg;
  localparam int unsigned FracBitsDef  = 14;
  localparam int unsigned CompWidthDef = 16;
  localparam int unsigned QDepth       = 2;

  typedef enum logic [1:0] {
    FUNC_MUL  = 2'd0,
    FUNC_NORM = 2'd1,
    FUNC_INV  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;
endpackage

### design/qalu_front.sv
// Front end: accepts items, classifies the operation and holds them in a short queue.
// Depends on qalu_pkg.
module qalu_front #(
  parameter int unsigned CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            func_i,
  input  logic [8*CW-1:0]       ops_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output qalu_pkg::func_e       func_o,
  output logic [8*CW-1:0]       ops_o
);
  import qalu_pkg::*;
  localparam int unsigned PW = 8*CW + 2;
  logic [PW-1:0] mem_q [QDepth];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       wr, rd;

  assign full_o = (cnt_q == 2'(QDepth));
  assign vld_o  = (cnt_q != 2'd0);
  assign wr     = push_i && !full_o;
  assign rd     = vld_o && rdy_i;
  assign cnt_d  = cnt_q + {1'b0, wr} - {1'b0, rd};
  assign func_o = func_e'(mem_q[rp_q][PW-1 -: 2]);
  assign ops_o  = mem_q[rp_q][8*CW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= {func_i, ops_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
    end
  end
endmodule

### design/qalu_back.sv
// Back end: pipelined Hamilton product, square root and division with an output queue.
// Depends on qalu_pkg.
module qalu_back #(
  parameter int unsigned FB = 14,
  parameter int unsigned CW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  output logic             rdy_o,
  input  qalu_pkg::func_e  func_i,
  input  logic [8*CW-1:0]  ops_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [4*CW+1:0]  res_o
);
  import qalu_pkg::*;
  localparam int unsigned PR = 2*CW + 2;
  localparam int unsigned SW = 2*CW + 3;
  localparam int unsigned RW = SW/2 + 1;
  localparam int unsigned SQS = (SW + 1) / 2;
  localparam int unsigned NW = CW + 1 + FB;
  localparam int unsigned DS = NW;
  localparam int unsigned NST = 2 + SQS + DS + 1;
  localparam int unsigned ODEP = NST + 3;
  localparam int unsigned OAW = $clog2(ODEP + 1);
  localparam logic signed [CW+1:0] CMax = (CW+2)'((1 << (CW-1)) - 1);
  localparam logic signed [CW+1:0] CMin = -CMax - 1;
  localparam logic [NW-1:0] QLim = NW'(1) << (CW-1);

  typedef struct packed {
    func_e         f;
    logic [4*CW-1:0] a;
  } tag_t;

  // output queue with room for every item in flight, head register in front
  logic [4*CW+1:0] oq_q [ODEP];
  logic [4*CW+1:0] hd_q;
  logic hv_q;
  logic [OAW-1:0] ocnt_q, mcnt_q, inflt_q;
  logic [$clog2(ODEP)-1:0] owp_q, orp_q;
  logic acc, ovld, opop, hld;

  assign rdy_o = (32'(ocnt_q) + 32'(inflt_q)) < ODEP;
  assign acc   = vld_i && rdy_o;

  // stage 1: products
  logic signed [CW-1:0] a [4], b [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = ops_i[i*CW +: CW];
      b[i] = ops_i[(4+i)*CW +: CW];
    end
  end
  logic signed [PR-1:0] p1_q [16];
  tag_t t1_q;
  always_ff @(posedge clk_i) begin
    logic signed [2*CW-1:0] pr;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        pr = a[i] * ((func_i == FUNC_MUL) ? b[j] : a[j]);
        p1_q[i*4+j] <= PR'(pr);
      end
    t1_q.f <= func_i;
    t1_q.a <= ops_i[4*CW-1:0];
  end

  // stage 2: sums
  logic signed [PR-1:0] s_d [4];
  logic [SW-1:0] ss_d;
  always_comb begin
    s_d[0] = p1_q[0] - p1_q[5] - p1_q[10] - p1_q[15];
    s_d[1] = p1_q[1] + p1_q[4] + p1_q[11] - p1_q[14];
    s_d[2] = p1_q[2] + p1_q[8] + p1_q[13] - p1_q[7];
    s_d[3] = p1_q[3] + p1_q[12] + p1_q[6] - p1_q[9];
    ss_d = SW'(p1_q[0]) + SW'(p1_q[5]) + SW'(p1_q[10]) + SW'(p1_q[15]);
  end
  logic signed [CW-1:0] mr_q [4];
  logic ms_q;
  logic [SW-1:0] ss2_q;
  tag_t t2_q;
  always_ff @(posedge clk_i) begin
    logic signed [PR-1:0] sh;
    logic sat;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sh = s_d[i] >>> FB;
      if (sh > PR'(CMax)) begin
        mr_q[i] <= CMax[CW-1:0]; sat = 1'b1;
      end else if (sh < PR'(CMin)) begin
        mr_q[i] <= CMin[CW-1:0]; sat = 1'b1;
      end else mr_q[i] <= sh[CW-1:0];
    end
    ms_q  <= sat;
    ss2_q <= ss_d;
    t2_q.f <= t1_q.f;
    t2_q.a <= t1_q.a;
  end

  // square root, one result bit per stage
  logic [SW-1:0] sq_n_q [SQS+1];
  logic [RW-1:0] sq_r_q [SQS+1];
  logic signed [CW-1:0] sm_r_q [SQS+1][4];
  logic sm_s_q [SQS+1];
  tag_t sq_t_q [SQS+1];
  always_comb begin
    sq_n_q[0] = ss2_q;
    sq_r_q[0] = '0;
    sm_r_q[0] = mr_q;
    sm_s_q[0] = ms_q;
    sq_t_q[0] = t2_q;
  end
  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam int unsigned Sh = 2*(SQS-1-k);
    always_ff @(posedge clk_i) begin
      logic [SW+1:0] trial;
      trial = ({2'b0, SW'(sq_r_q[k])} << (Sh + 2)) | ({(SW+2){1'b0}} | ((SW+2)'(1) << Sh));
      if ({2'b0, sq_n_q[k]} >= trial) begin
        sq_n_q[k+1] <= sq_n_q[k] - trial[SW-1:0];
        sq_r_q[k+1] <= {sq_r_q[k][RW-2:0], 1'b1};
      end else begin
        sq_n_q[k+1] <= sq_n_q[k];
        sq_r_q[k+1] <= {sq_r_q[k][RW-2:0], 1'b0};
      end
      sm_r_q[k+1] <= sm_r_q[k];
      sm_s_q[k+1] <= sm_s_q[k];
      sq_t_q[k+1] <= sq_t_q[k];
    end
  end

  // division setup: magnitudes, divisor, sign
  logic [RW-1:0] m;
  logic zero;
  assign zero = (sq_r_q[SQS] == '0);
  assign m = (zero) ? RW'(1 << FB) : sq_r_q[SQS];

  logic [NW-1:0] dq_q [DS+1][4];
  logic [NW+RW:0] dr_q [DS+1][4];
  logic dneg_q [DS+1][4];
  logic [RW-1:0] dm_q [DS+1];
  logic dz_q [DS+1];
  logic signed [CW-1:0] dmr_q [DS+1][4];
  logic dms_q [DS+1];
  tag_t dt_q [DS+1];
  always_comb begin
    logic signed [CW:0] c;
    for (int i = 0; i < 4; i++) begin
      c = {sq_t_q[SQS].a[i*CW+CW-1], sq_t_q[SQS].a[i*CW +: CW]};
      if (sq_t_q[SQS].f == FUNC_INV && i != 0) c = -c;
      dneg_q[0][i] = c[CW];
      dq_q[0][i] = {(c[CW] ? NW'(-c) : NW'(c))} << FB;
      dr_q[0][i] = '0;
    end
    dm_q[0] = m;
    dz_q[0] = zero;
    dmr_q[0] = sm_r_q[SQS];
    dms_q[0] = sm_s_q[SQS];
    dt_q[0] = sq_t_q[SQS];
  end
  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [NW+RW:0] r;
      for (int i = 0; i < 4; i++) begin
        r = {dr_q[k][i][NW+RW-1:0], dq_q[k][i][NW-1]};
        if (r >= (NW+RW+1)'(dm_q[k])) begin
          dr_q[k+1][i] <= r - (NW+RW+1)'(dm_q[k]);
          dq_q[k+1][i] <= {dq_q[k][i][NW-2:0], 1'b1};
        end else begin
          dr_q[k+1][i] <= r;
          dq_q[k+1][i] <= {dq_q[k][i][NW-2:0], 1'b0};
        end
        dneg_q[k+1][i] <= dneg_q[k][i];
        dmr_q[k+1][i] <= dmr_q[k][i];
      end
      dm_q[k+1] <= dm_q[k];
      dz_q[k+1] <= dz_q[k];
      dms_q[k+1] <= dms_q[k];
      dt_q[k+1] <= dt_q[k];
    end
  end

  // final select and saturation
  logic [4*CW+1:0] fin_q;
  always_ff @(posedge clk_i) begin
    logic [NW-1:0] q;
    logic signed [CW+1:0] v;
    logic sat;
    logic [CW-1:0] r [4];
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      q = (dq_q[DS][i] > QLim) ? QLim : dq_q[DS][i];
      v = dneg_q[DS][i] ? -(CW+2)'(q) : (CW+2)'(q);
      if (v > CMax) begin
        r[i] = CMax[CW-1:0]; sat = 1'b1;
      end else r[i] = v[CW-1:0];
    end
    case (dt_q[DS].f)
      FUNC_MUL:  fin_q <= {1'b0, dms_q[DS], dmr_q[DS][3], dmr_q[DS][2], dmr_q[DS][1],
                           dmr_q[DS][0]};
      FUNC_NORM: fin_q <= dz_q[DS] ? {1'b1, 1'b0, dt_q[DS].a}
                                   : {1'b0, sat, r[3], r[2], r[1], r[0]};
      FUNC_INV:  fin_q <= {dz_q[DS], sat, r[3], r[2], r[1], r[0]};
      default:   fin_q <= '0;
    endcase
  end

  // valid bits through the pipe
  logic [NST-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[NST-2:0], acc};
  end

  assign ovld    = v_q[NST-1];
  assign empty_o = !hv_q;
  assign opop    = pop_i && hv_q;
  assign hld     = (mcnt_q != '0) && (!hv_q || opop);
  assign res_o   = hd_q;

  always_ff @(posedge clk_i) begin
    if (ovld) oq_q[owp_q] <= fin_q;
    if (hld) hd_q <= oq_q[orp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0; mcnt_q <= '0; inflt_q <= '0; owp_q <= '0; orp_q <= '0;
      hv_q <= 1'b0;
    end else begin
      ocnt_q  <= ocnt_q + OAW'(ovld) - OAW'(opop);
      mcnt_q  <= mcnt_q + OAW'(ovld) - OAW'(hld);
      inflt_q <= inflt_q + OAW'(acc) - OAW'(ovld);
      if (hld) hv_q <= 1'b1;
      else if (opop) hv_q <= 1'b0;
      if (ovld) owp_q <= (32'(owp_q) == ODEP-1) ? '0 : owp_q + 1'b1;
      if (hld) orp_q <= (32'(orp_q) == ODEP-1) ? '0 : orp_q + 1'b1;
    end
  end
endmodule

### design/quaternion_alu.sv
// Top level of the quaternion ALU: front queue and pipelined back end.
// Depends on qalu_pkg, qalu_front, qalu_back.
//  channel | handshake     | payload
//  input   | push/full     | func_i, a_*_i, b_*_i
//  result  | empty/pop     | r_*_o, saturated_o, zero_magnitude_o
// One item per cycle sustained while the result side keeps popping; an accepted item
// passes two product/sum stages, ceil((2*CW+3)/2) square root stages, CW+1+FRAC_BITS
// divide stages, one final stage, then the output queue and its head register.
// Reset clears all queue and pipeline valid state.
// A stalled result side fills the output queue, then full rises.
module quaternion_alu #(
  parameter int unsigned FRAC_BITS  = qalu_pkg::FracBitsDef,
  parameter int unsigned COMP_WIDTH = qalu_pkg::CompWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   func_i,
  input  logic signed [COMP_WIDTH-1:0] a_w_i, a_x_i, a_y_i, a_z_i,
  input  logic signed [COMP_WIDTH-1:0] b_w_i, b_x_i, b_y_i, b_z_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COMP_WIDTH-1:0] r_w_o, r_x_o, r_y_o, r_z_o,
  output logic                         saturated_o,
  output logic                         zero_magnitude_o
);
  import qalu_pkg::*;
  localparam int unsigned CW = COMP_WIDTH;
  logic vld, rdy;
  func_e fn;
  logic [8*CW-1:0] ops, ops_q;
  logic [4*CW+1:0] res;

  assign ops = {b_z_i, b_y_i, b_x_i, b_w_i, a_z_i, a_y_i, a_x_i, a_w_i};

  qalu_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .func_i, .ops_i(ops),
    .vld_o(vld), .rdy_i(rdy), .func_o(fn), .ops_o(ops_q)
  );

  qalu_back #(.FB(FRAC_BITS), .CW(CW)) u_back (
    .clk_i, .rst_ni, .vld_i(vld), .rdy_o(rdy), .func_i(fn), .ops_i(ops_q),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign {zero_magnitude_o, saturated_o, r_z_o, r_y_o, r_x_o, r_w_o} = res;
endmodule

### design/quaternion_alu_chk.sv
// Port checker for the quaternion ALU and its bind.
// Depends on quaternion_alu_macros.svh.
`include "quaternion_alu_macros.svh"
module quaternion_alu_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic saturated_o,
  input logic zero_magnitude_o
);
  `QA_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty)
  `QA_ASSERT_NXT(a_flags, clk_i, rst_ni, !empty && !pop, $stable(saturated_o))
  `QA_ASSERT_NXT(a_zm, clk_i, rst_ni, !empty && !pop, $stable(zero_magnitude_o))
  `QA_ASSERT_NXT(a_full, clk_i, rst_ni, !push && !full, !full)
  `QA_ASSERT_IMP(a_rst, clk_i, 1'b1, !rst_ni, empty && !full)
endmodule

bind quaternion_alu quaternion_alu_chk u_chk (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .saturated_o, .zero_magnitude_o
);

### tb/quaternion_alu_test.sv
// Self-checking testbench for quaternion_alu: directed table, then random items,
// with both queue sides idling at random. Depends on qalu_pkg and the quaternion_alu RTL.
module quaternion_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qalu_pkg::*;

  localparam int Cw = CompWidthDef;
  localparam int Fb = FracBitsDef;
  localparam longint CompMax = (64'sd1 <<< (Cw - 1)) - 1;
  localparam longint CompMin = -CompMax - 1;
  localparam int NumRandom = 630;

  typedef logic signed [Cw-1:0] comp_t;

  typedef struct {
    func_e func;
    comp_t a[4];
    comp_t b[4];
    bit    known;
    comp_t r[4];
    bit    sat;
    bit    zm;
  } quat_op_t;

  typedef struct {
    comp_t r[4];
    bit    sat;
    bit    zm;
  } quat_res_t;

  logic clk_i, rst_ni, push, full, empty, pop;
  logic [1:0] func_i;
  comp_t a_w_i, a_x_i, a_y_i, a_z_i, b_w_i, b_x_i, b_y_i, b_z_i;
  comp_t r_w_o, r_x_o, r_y_o, r_z_o;
  logic saturated_o, zero_magnitude_o;

  quat_res_t pending_q[$];
  int errors = 0;
  int accepted = 0;
  bit quiet = 0;

  quaternion_alu dut (
    .clk_i, .rst_ni, .push, .full, .func_i,
    .a_w_i, .a_x_i, .a_y_i, .a_z_i, .b_w_i, .b_x_i, .b_y_i, .b_z_i,
    .empty, .pop, .r_w_o, .r_x_o, .r_y_o, .r_z_o, .saturated_o, .zero_magnitude_o
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip_comp(input longint v, inout bit s);
    if (v > CompMax) begin
      s = 1;
      return CompMax;
    end
    if (v < CompMin) begin
      s = 1;
      return CompMin;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint scaled_div(input longint v, input longint unsigned m, inout bit s);
    longint unsigned mag = (v < 0) ? -v : v;
    longint unsigned q = (mag << Fb) / m;
    if (q > CompMax + 1) q = CompMax + 1;
    return clip_comp((v < 0) ? -longint'(q) : longint'(q), s);
  endfunction

  function automatic quat_res_t quat_eval(input quat_op_t op);
    quat_res_t res;
    longint a[4], b[4], v[4], sum[4];
    longint unsigned m;
    bit s = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = op.a[i];
      b[i] = op.b[i];
      v[i] = 0;
    end
    res.zm = 0;
    case (op.func)
      FUNC_MUL: begin
        sum[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        sum[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        sum[2] = a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3];
        sum[3] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
        for (int i = 0; i < 4; i++) v[i] = clip_comp(sum[i] >>> Fb, s);
      end
      FUNC_NORM, FUNC_INV: begin
        m = floor_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
        res.zm = (m == 0);
        if (op.func == FUNC_NORM && res.zm) begin
          for (int i = 0; i < 4; i++) v[i] = a[i];
        end else begin
          if (res.zm) m = 64'd1 << Fb;
          for (int i = 0; i < 4; i++)
            v[i] = scaled_div((op.func == FUNC_INV && i > 0) ? -a[i] : a[i], m, s);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = comp_t'(v[i]);
    res.sat = s;
    return res;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(CompMax);
      1: return comp_t'(CompMin);
      2: return comp_t'($urandom_range(0, 64) - 32);
      3: return comp_t'($urandom_range(0, 2)) <<< 14;
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic quat_op_t mk(func_e f, int aw, ax, ay, az, bw, bx, by, bz);
    quat_op_t op;
    op.func = f;
    op.a = '{comp_t'(aw), comp_t'(ax), comp_t'(ay), comp_t'(az)};
    op.b = '{comp_t'(bw), comp_t'(bx), comp_t'(by), comp_t'(bz)};
    op.known = 0;
    op.r = '{0, 0, 0, 0};
    op.sat = 0;
    op.zm = 0;
    return op;
  endfunction

  function automatic quat_op_t mk_exp(quat_op_t op, int rw, rx, ry, rz, bit s, bit z);
    op.known = 1;
    op.r = '{comp_t'(rw), comp_t'(rx), comp_t'(ry), comp_t'(rz)};
    op.sat = s;
    op.zm = z;
    return op;
  endfunction

  quat_op_t directed[$];

  initial begin
    directed = '{
      mk_exp(mk(FUNC_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0), 16384, 0, 0, 0, 0, 0),
      mk_exp(mk(FUNC_MUL, 0, 16384, 0, 0, 0, 16384, 0, 0), -16384, 0, 0, 0, 0, 0),
      mk_exp(mk(FUNC_MUL, 32767, 0, 0, 0, 32767, 0, 0, 0), 32767, 0, 0, 0, 1, 0),
      mk_exp(mk(FUNC_MUL, -32768, 0, 0, 0, -32768, 0, 0, 0), 32767, 0, 0, 0, 1, 0),
      mk_exp(mk(FUNC_NORM, 0, 0, 0, 0, 5, 6, 7, 8), 0, 0, 0, 0, 0, 1),
      mk_exp(mk(FUNC_INV, 0, 0, 0, 0, -1, -1, -1, -1), 0, 0, 0, 0, 0, 1),
      mk_exp(mk(FUNC_NONE, 123, -32768, 32767, -1, 9, 8, 7, 6), 0, 0, 0, 0, 0, 0),
      mk_exp(mk(FUNC_NORM, 16384, 0, 0, 0, 0, 0, 0, 0), 16384, 0, 0, 0, 0, 0),
      mk_exp(mk(FUNC_INV, 16384, 0, 0, 0, 0, 0, 0, 0), 16384, 0, 0, 0, 0, 0),
      mk(FUNC_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      mk(FUNC_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
      mk(FUNC_MUL, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767),
      mk(FUNC_MUL, -1, -1, -1, -1, 1, 1, 1, 1),
      mk(FUNC_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0),
      mk(FUNC_NORM, 32767, -32768, 32767, -32768, 0, 0, 0, 0),
      mk(FUNC_NORM, 1, 0, 0, 0, 0, 0, 0, 0),
      mk(FUNC_NORM, 0, 0, 0, -1, 0, 0, 0, 0),
      mk(FUNC_INV, -32768, -32768, -32768, -32768, 0, 0, 0, 0),
      mk(FUNC_INV, 0, -32768, 0, 0, 0, 0, 0, 0),
      mk(FUNC_INV, 1, 1, 1, 1, 0, 0, 0, 0),
      mk(FUNC_INV, 0, 0, 1, 0, 0, 0, 0, 0),
      mk(FUNC_INV, 32767, 32767, 32767, 32767, 0, 0, 0, 0)
    };
  end

  // sender
  initial begin
    quat_op_t op;
    quat_res_t exp_res;
    int total;
    rst_ni = 0;
    push = 0;
    func_i = FUNC_MUL;
    {a_w_i, a_x_i, a_y_i, a_z_i, b_w_i, b_x_i, b_y_i, b_z_i} = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    total = directed.size() + NumRandom;
    for (int n = 0; n < total; n++) begin
      if (n < directed.size()) begin
        op = directed[n];
      end else begin
        op = mk(func_e'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)),
                0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) begin
          op.a[i] = rand_comp();
          op.b[i] = rand_comp();
        end
      end
      if (n == 400) begin
        push <= 0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end else if (n < total - 80 && $urandom_range(0, 3) == 0) begin
        push <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      if (n == total - 80) quiet = 1;
      push <= 1;
      func_i <= op.func;
      a_w_i <= op.a[0]; a_x_i <= op.a[1]; a_y_i <= op.a[2]; a_z_i <= op.a[3];
      b_w_i <= op.b[0]; b_x_i <= op.b[1]; b_y_i <= op.b[2]; b_z_i <= op.b[3];
      do @(posedge clk_i); while (full);
      if (op.known) begin
        exp_res.r = op.r;
        exp_res.sat = op.sat;
        exp_res.zm = op.zm;
      end else begin
        exp_res = quat_eval(op);
      end
      pending_q.push_back(exp_res);
      accepted++;
    end
    push <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver
  initial begin
    quat_res_t e;
    int stall;
    bit held;
    stall = 0;
    held = 0;
    pop = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          $error("unexpected item r_w %0d", r_w_o);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (r_w_o !== e.r[0]) begin
            $error("r_w exp %0d got %0d", e.r[0], r_w_o); errors++;
          end
          if (r_x_o !== e.r[1]) begin
            $error("r_x exp %0d got %0d", e.r[1], r_x_o); errors++;
          end
          if (r_y_o !== e.r[2]) begin
            $error("r_y exp %0d got %0d", e.r[2], r_y_o); errors++;
          end
          if (r_z_o !== e.r[3]) begin
            $error("r_z exp %0d got %0d", e.r[3], r_z_o); errors++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated exp %0d got %0d", e.sat, saturated_o); errors++;
          end
          if (zero_magnitude_o !== e.zm) begin
            $error("zero_magnitude exp %0d got %0d", e.zm, zero_magnitude_o); errors++;
          end
        end
      end
      if (!held && accepted >= 200) begin
        held = 1;
        stall = 200;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
      end
      if (stall > 0) begin
        stall--;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
